FILE: rtl/core/pdr_pkg.sv
// pdr_pkg: shared widths, reset values, register indexes and the config bundle
// for the difficulty retarget pipeline. No dependencies.
package pdr_pkg;

    localparam int TS_W   = 31;  // target timespan
    localparam int HGT_W  = 31;  // block height
    localparam int CW     = 32;  // compact word
    localparam int SPAN_W = 33;  // clamped timespan, up to 4*T
    localparam int DIFF_W = 34;  // signed raw timespan
    localparam int ADJ_W  = 35;  // signed damped timespan

    localparam int FIXED_LAT = 7;  // register stages outside the divider stages

    localparam logic [HGT_W:0]  HEIGHT_HI     = 32'd10000;
    localparam logic [HGT_W:0]  HEIGHT_MID    = 32'd5000;
    localparam logic [TS_W-1:0] TIMESPAN_RST  = 31'd60;
    localparam logic [CW-1:0]   POW_LIMIT_RST = 32'h1E0F_FFFF;

    typedef enum logic [1:0] {
        CFG_TIMESPAN  = 2'd0,
        CFG_DAMPED    = 2'd1,
        CFG_POW_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TS_W-1:0] timespan;
        logic            damped;
        logic [CW-1:0]   pow_limit;
    } t_cfg;

endpackage

FILE: rtl/core/pdr_decode.sv
// pdr_decode: compact exponent/mantissa word to a TB-bit integer.
// Combinational byte shifter; uses pdr_pkg.
module pdr_decode
    import pdr_pkg::*;
#(
    parameter int TB = 256
) (
    input  logic [CW-1:0] i_compact,
    output logic [TB-1:0] o_value
);

    logic [TB+23:0] w_wide;

    // value = (m << 8e) >> 24, sign bit ignored; shifts past the top drop out
    assign w_wide  = (TB + 24)'(i_compact[22:0]) << {i_compact[31:24], 3'b000};
    assign o_value = w_wide[TB+23:24];

endmodule

FILE: rtl/core/pdr_front.sv
// pdr_front: timespan filter and clamp, old target decode (two stages).
// Uses pdr_pkg and pdr_decode.
module pdr_front
    import pdr_pkg::*;
#(
    parameter int TB = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  logic [HGT_W-1:0]  i_last_height,
    input  logic [CW-1:0]     i_last_block_time,
    input  logic [CW-1:0]     i_first_block_time,
    input  logic [CW-1:0]     i_old_compact_target,
    output logic              o_valid,
    output logic [TB-1:0]     o_value,
    output logic [SPAN_W-1:0] o_span
);

    logic [TS_W-1:0]          w_t;
    logic [HGT_W:0]           w_height;
    logic [SPAN_W-1:0]        n_lo, n_hi;
    logic signed [DIFF_W-1:0] n_diff;
    logic [TB-1:0]            w_dec;

    logic                     r_a_v, r_damp;
    logic signed [DIFF_W-1:0] r_diff;
    logic [SPAN_W-1:0]        r_lo, r_hi;
    logic [TB-1:0]            r_a_val;

    logic signed [ADJ_W-1:0]  w_dev, w_q, w_adj, w_lo_s, w_hi_s, w_t_s;
    logic                     w_round;
    logic [SPAN_W-1:0]        n_span;

    logic                     r_b_v;
    logic [SPAN_W-1:0]        r_span;
    logic [TB-1:0]            r_b_val;

    assign w_t      = i_cfg.timespan;
    assign w_height = {1'b0, i_last_height} + (HGT_W + 1)'(1);
    assign n_diff   = $signed({2'b00, i_last_block_time})
                    - $signed({2'b00, i_first_block_time});

    pdr_decode #(.TB(TB)) u_dec (
        .i_compact (i_old_compact_target),
        .o_value   (w_dec)
    );

    always_comb begin
        if (i_cfg.damped) begin
            n_lo = SPAN_W'(w_t) - SPAN_W'(w_t >> 2);
            n_hi = SPAN_W'(w_t) + SPAN_W'(w_t >> 1);
        end else begin
            if (w_height > HEIGHT_HI) begin
                n_lo = SPAN_W'(w_t >> 2);
            end else if (w_height > HEIGHT_MID) begin
                n_lo = SPAN_W'(w_t >> 3);
            end else begin
                n_lo = SPAN_W'(w_t >> 4);
            end
            n_hi = {w_t, 2'b00};
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff  <= n_diff;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_damp  <= i_cfg.damped;
        r_a_val <= w_dec;
    end

    // stage B: T + (span - T)/8 toward zero when damped, else raw span; then clamp
    assign w_t_s   = $signed({4'b0000, w_t});
    assign w_dev   = ADJ_W'(r_diff) - w_t_s;
    assign w_round = w_dev[ADJ_W-1] && (w_dev[2:0] != 3'b000);
    assign w_q     = (w_dev >>> 3) + $signed({{(ADJ_W-1){1'b0}}, w_round});
    assign w_adj   = r_damp ? (w_t_s + w_q) : ADJ_W'(r_diff);
    assign w_lo_s  = $signed({2'b00, r_lo});
    assign w_hi_s  = $signed({2'b00, r_hi});

    always_comb begin
        if (w_adj < w_lo_s) begin
            n_span = r_lo;
        end else if (w_adj > w_hi_s) begin
            n_span = r_hi;
        end else begin
            n_span = w_adj[SPAN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span  <= n_span;
        r_b_val <= r_a_val;
    end

    assign o_valid = r_b_v;
    assign o_value = r_b_val;
    assign o_span  = r_span;

endmodule

FILE: rtl/core/pdr_mul.sv
// pdr_mul: TB-bit by 33-bit wrapping multiply; 32x32 limb products, then sum.
// Two stages; uses pdr_pkg.
module pdr_mul
    import pdr_pkg::*;
#(
    parameter int TB = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [TB-1:0]     i_value,
    input  logic [SPAN_W-1:0] i_span,
    output logic              o_valid,
    output logic [TB-1:0]     o_prod
);

    localparam int NL = (TB + 31) / 32;
    localparam int LW = NL * 32;

    logic [LW-1:0]    w_limbs;
    logic [63:0]      r_pp [NL];
    logic             r_m_v, r_hibit;
    logic [TB-1:0]    r_val_d;
    logic [LW+31:0]   w_even, w_odd;
    logic [TB-1:0]    w_hiterm;
    logic             r_p_v;
    logic [TB-1:0]    r_prod;

    assign w_limbs = LW'(i_value);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NL; i++) begin
            r_pp[i] <= 64'(w_limbs[32*i +: 32]) * 64'(i_span[31:0]);
        end
        r_hibit <= i_span[32];
        r_val_d <= i_value;
    end

    // even and odd limb products do not overlap among themselves
    always_comb begin
        w_even = '0;
        w_odd  = '0;
        for (int i = 0; i < NL; i++) begin
            if ((i % 2) == 0) begin
                w_even[32*i +: 64] = r_pp[i];
            end else begin
                w_odd[32*i +: 64] = r_pp[i];
            end
        end
    end

    assign w_hiterm = r_hibit ? {r_val_d[TB-33:0], 32'h0} : '0;

    always_ff @(posedge i_clk) begin
        r_prod <= TB'(w_even) + TB'(w_odd) + w_hiterm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_p_v <= 1'b0;
        end else begin
            r_m_v <= i_valid;
            r_p_v <= r_m_v;
        end
    end

    assign o_valid = r_p_v;
    assign o_prod  = r_prod;

endmodule

FILE: rtl/core/pdr_div.sv
// pdr_div: restoring divide of a TB-bit word by the 31-bit timespan,
// one quotient bit per stage, TB stages. Uses pdr_pkg.
module pdr_div
    import pdr_pkg::*;
#(
    parameter int TB = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [TB-1:0]   i_value,
    input  logic [TS_W-1:0] i_divisor,
    output logic            o_valid,
    output logic [TB-1:0]   o_quot
);

    // dividend bits leave at the top of r_q while quotient bits enter below
    logic [TS_W-1:0] r_rem [TB];
    logic [TB-1:0]   r_q   [TB];
    logic            r_v   [TB];
    logic [TS_W-1:0] n_rem [TB];
    logic [TB-1:0]   n_q   [TB];

    always_comb begin
        logic [TS_W-1:0] v_rem;
        logic [TB-1:0]   v_q;
        logic [TS_W:0]   v_try;
        logic            v_ge;
        for (int k = 0; k < TB; k++) begin
            if (k == 0) begin
                v_rem = '0;
                v_q   = i_value;
            end else begin
                v_rem = r_rem[k-1];
                v_q   = r_q[k-1];
            end
            v_try    = {v_rem, v_q[TB-1]};
            v_ge     = v_try >= {1'b0, i_divisor};
            // a zero divisor gives all ones, the saturated quotient
            n_rem[k] = v_ge ? TS_W'(v_try - {1'b0, i_divisor}) : v_try[TS_W-1:0];
            n_q[k]   = {v_q[TB-2:0], v_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < TB; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TB; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < TB; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_valid = r_v[TB-1];
    assign o_quot  = r_q[TB-1];

endmodule

FILE: rtl/core/pdr_enc.sv
// pdr_enc: cap at the decoded limit, find significant bytes, pack compact word.
// Three stages; uses pdr_pkg and pdr_decode.
module pdr_enc
    import pdr_pkg::*;
#(
    parameter int TB = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [TB-1:0] i_value,
    input  logic [CW-1:0] i_limit_compact,
    output logic          o_valid,
    output logic [CW-1:0] o_compact
);

    localparam int NB = (TB + 7) / 8;

    logic [TB-1:0]     w_lim;
    logic              r_c_v, r_s_v, r_o_v;
    logic [TB-1:0]     r_c_val;
    logic [NB*8-1:0]   w_pad, r_s_val;
    logic [7:0]        n_size, r_size;
    logic [NB*8+23:0]  w_ext;
    logic [23:0]       w_mant;
    logic [CW-1:0]     n_out, r_out;

    pdr_decode #(.TB(TB)) u_lim (
        .i_compact (i_limit_compact),
        .o_value   (w_lim)
    );

    always_ff @(posedge i_clk) begin
        r_c_val <= (i_value > w_lim) ? w_lim : i_value;
    end

    assign w_pad = (NB * 8)'(r_c_val);

    always_comb begin
        n_size = '0;
        for (int j = 0; j < NB; j++) begin
            if (w_pad[8*j +: 8] != 8'h00) begin
                n_size = 8'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size  <= n_size;
        r_s_val <= w_pad;
    end

    // top significant byte and the two below it; zero fill for short values
    assign w_ext  = {r_s_val, 24'h0};
    assign w_mant = 24'(w_ext >> {r_size, 3'b000});

    always_comb begin
        if (w_mant[23]) begin
            n_out = {r_size + 8'd1, 8'h00, w_mant[23:8]};
        end else begin
            n_out = {r_size, w_mant};
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
            r_s_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            r_c_v <= i_valid;
            r_s_v <= r_c_v;
            r_o_v <= r_s_v;
        end
    end

    assign o_valid   = r_o_v;
    assign o_compact = r_out;

endmodule

FILE: rtl/core/pow_difficulty_retarget.sv
// pow_difficulty_retarget: top level, config registers and the retarget pipe.
// Uses pdr_pkg, pdr_front, pdr_mul, pdr_div, pdr_enc.
//
//  channel  | direction | handshake                     | word
//  ---------+-----------+-------------------------------+-------------------------------
//  command  | in        | i_start & !o_busy             | height, two timestamps, target
//  result   | out       | o_done, one cycle, no stall   | o_new_compact_target
//  config   | in        | i_cfg_valid & o_cfg_ready     | i_cfg_index, i_cfg_data
//
// One word enters per clock while o_busy is low. Each word passes, in order,
// through the timespan filter and decode, the limb multiply and sum, the
// one-bit-per-stage divider and the cap and compact encode.
// o_busy is high only while reset is applied and the cycle after it.
// Nothing stalls: every stage moves each cycle and results leave on o_done.
module pow_difficulty_retarget
    import pdr_pkg::*;
#(
    parameter int TARGET_BITS = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [HGT_W-1:0] i_last_height,
    input  logic [CW-1:0]    i_last_block_time,
    input  logic [CW-1:0]    i_first_block_time,
    input  logic [CW-1:0]    i_old_compact_target,
    output logic             o_done,
    output logic [CW-1:0]    o_new_compact_target,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [CW-1:0]    i_cfg_data
);

    t_cfg              r_cfg;
    logic              r_busy;
    logic              w_accept;
    logic              w_f_v, w_m_v, w_d_v;
    logic [TARGET_BITS-1:0] w_f_val, w_prod, w_quot;
    logic [SPAN_W-1:0] w_span;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_busy;
    assign w_accept    = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // register file; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timespan  <= TIMESPAN_RST;
            r_cfg.damped    <= 1'b1;
            r_cfg.pow_limit <= POW_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TIMESPAN:  r_cfg.timespan  <= i_cfg_data[TS_W-1:0];
                CFG_DAMPED:    r_cfg.damped    <= i_cfg_data[0];
                CFG_POW_LIMIT: r_cfg.pow_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // filtered and clamped timespan, decoded old target
    pdr_front #(.TB(TARGET_BITS)) u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_valid              (w_accept),
        .i_last_height        (i_last_height),
        .i_last_block_time    (i_last_block_time),
        .i_first_block_time   (i_first_block_time),
        .i_old_compact_target (i_old_compact_target),
        .o_valid              (w_f_v),
        .o_value              (w_f_val),
        .o_span               (w_span)
    );

    // target * timespan, wrapping
    pdr_mul #(.TB(TARGET_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_v),
        .i_value (w_f_val),
        .i_span  (w_span),
        .o_valid (w_m_v),
        .o_prod  (w_prod)
    );

    // divide by timespan; config held steady by user while words in flight, unenforced
    pdr_div #(.TB(TARGET_BITS)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_m_v),
        .i_value   (w_prod),
        .i_divisor (r_cfg.timespan),
        .o_valid   (w_d_v),
        .o_quot    (w_quot)
    );

    // cap at the limit and re-encode
    pdr_enc #(.TB(TARGET_BITS)) u_enc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_d_v),
        .i_value         (w_quot),
        .i_limit_compact (r_cfg.pow_limit),
        .o_valid         (o_done),
        .o_compact       (o_new_compact_target)
    );

endmodule

FILE: rtl/core/pdr_chk.sv
// pdr_chk: port-level checks for pow_difficulty_retarget, bound to the top.
// Uses pdr_pkg.
module pdr_chk
    import pdr_pkg::*;
#(
    parameter int TARGET_BITS = 256
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_start,
    input logic          o_busy,
    input logic          o_done,
    input logic [CW-1:0] o_new_compact_target
);

    localparam int LAT = TARGET_BITS + FIXED_LAT;

    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LAT))
        else $error("result without an accepted word");

    a_start_gets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_done)
        else $error("accepted word produced no result");

    a_sign_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_new_compact_target[23] == 1'b0))
        else $error("compact result has sign bit set");

    a_busy_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy after reset");

endmodule

bind pow_difficulty_retarget pdr_chk #(.TARGET_BITS(TARGET_BITS)) u_chk (.*);
